/* src/ucv_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the comment code point rule for the utf-8 validator
package ucv_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // register indexes (byte address bit 2 selects the register)
  localparam logic REG_COMMENT_MODE = 1'b0;

  // lead and continuation byte patterns
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD2_TAG = 8'hC0;
  localparam logic [7:0] LEAD3_MSK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG = 8'hE0;
  localparam logic [7:0] LEAD4_MSK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG = 8'hF0;
  localparam logic [7:0] LEAD2_MSK = 8'hE0;

  // comment rule limits
  localparam logic [CpW-1:0] CP_C0_MAX = 21'h00001F;
  localparam logic [CpW-1:0] CP_TAB    = 21'h000009;
  localparam logic [CpW-1:0] CP_DEL    = 21'h00007F;
  localparam logic [CpW-1:0] CP_C1_MAX = 21'h00009F;
  localparam logic [CpW-1:0] CP_LSEP   = 21'h002028;
  localparam logic [CpW-1:0] CP_PSEP   = 21'h002029;

  typedef struct packed {
    logic [1:0]     bytes_left;
    logic [CpW-1:0] partial_code;
    logic           error_seen;
  } dec_state_t;

  typedef struct packed {
    logic           ok_so_far;
    logic           char_done;
    logic [CpW-1:0] code_point;
    logic           open_sequence;
  } dec_res_t;

  function automatic logic comment_allows(input logic [CpW-1:0] cp);
    logic allow;
    allow = 1'b1;
    if ((cp <= CP_C0_MAX) && (cp != CP_TAB)) allow = 1'b0;
    if (cp inside {[CP_DEL:CP_C1_MAX]}) allow = 1'b0;
    if ((cp == CP_LSEP) || (cp == CP_PSEP)) allow = 1'b0;
    return allow;
  endfunction

endpackage

/* src/ucv_cfg.sv */
`timescale 1ns / 1ps
// apb register file holding the comment mode bit
module ucv_cfg import ucv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic              comment_mode_o
);

  logic comment_mode_q, comment_mode_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_COMMENT_MODE);

  assign comment_mode_d = wr_en ? pwdata[0] : comment_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_mode_q <= 1'b0;
    end else begin
      comment_mode_q <= comment_mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COMMENT_MODE) prdata[0] = comment_mode_q;
  end

  assign comment_mode_o = comment_mode_q;

endmodule

/* src/ucv_decode.sv */
`timescale 1ns / 1ps
// per-byte decode step: next decoder state and the result fields
module ucv_decode import ucv_pkg::*; (
  input  dec_state_t cur_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       comment_mode_i,
  output dec_state_t nxt_o,
  output dec_res_t   res_o
);

  always_comb begin
    dec_state_t nxt;
    dec_res_t   res;
    logic       bad;
    nxt = cur_i;
    res = '0;
    bad = 1'b0;
    if (!cur_i.error_seen) begin
      if (cur_i.bytes_left != 2'd0) begin
        if ((byte_i & CONT_MASK) != CONT_TAG) begin
          bad = 1'b1;
        end else begin
          nxt.bytes_left   = cur_i.bytes_left - 2'd1;
          nxt.partial_code = {cur_i.partial_code[CpW-7:0], byte_i[5:0]};
        end
      end else if (!byte_i[7]) begin
        nxt.partial_code = {{(CpW-8){1'b0}}, byte_i};
      end else if ((byte_i & LEAD2_MSK) == LEAD2_TAG) begin
        nxt.bytes_left   = 2'd1;
        nxt.partial_code = {{(CpW-5){1'b0}}, byte_i[4:0]};
      end else if ((byte_i & LEAD3_MSK) == LEAD3_TAG) begin
        nxt.bytes_left   = 2'd2;
        nxt.partial_code = {{(CpW-4){1'b0}}, byte_i[3:0]};
      end else if ((byte_i & LEAD4_MSK) == LEAD4_TAG) begin
        nxt.bytes_left   = 2'd3;
        nxt.partial_code = {{(CpW-3){1'b0}}, byte_i[2:0]};
      end else begin
        bad = 1'b1;
      end

      if (bad) begin
        nxt.error_seen = 1'b1;
      end else if (nxt.bytes_left == 2'd0) begin
        res.char_done  = 1'b1;
        res.code_point = nxt.partial_code;
        if (comment_mode_i && !comment_allows(nxt.partial_code)) nxt.error_seen = 1'b1;
        nxt.partial_code = '0;
      end
      if (nxt.error_seen) begin
        nxt.bytes_left   = 2'd0;
        nxt.partial_code = '0;
      end
    end
    res.ok_so_far     = !nxt.error_seen;
    res.open_sequence = (nxt.bytes_left != 2'd0);
    // string boundary: start clean for the next string
    if (last_i) nxt = '0;
    nxt_o = nxt;
    res_o = res;
  end

endmodule

/* src/utf8_comment_validator_top.sv */
`timescale 1ns / 1ps
// top level of the utf-8 comment validator: byte register, decode step, result register
// a byte is registered on acceptance and its result registered when decoded
// throughput: one byte per cycle, sustained while the result side keeps taking results
// the decoder state loop (bytes left, partial code, error flag) runs through one register, state_q
// reset: asynchronous active-low; clears valids, decoder state and comment mode
// no clearing pass is needed after reset
module utf8_comment_validator_top import ucv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  // byte request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        byte_value_i,
  input  logic              last_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_so_far_o,
  output logic              char_done_o,
  output logic [CpW-1:0]    code_point_o,
  output logic              open_sequence_o,
  output logic              string_end_o
);

  logic comment_mode;

  ucv_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .comment_mode_o (comment_mode)
  );

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic     out_valid_q, out_valid_d;
  dec_res_t out_res_q;
  logic     out_last_q;

  // decoder state, updated when the byte in the input register moves on
  dec_state_t state_q, state_d;
  dec_state_t dec_nxt;
  dec_res_t   dec_res;

  logic out_free;   // result register can take a new result this cycle
  logic advance;    // byte in the input register is decoded into the result register
  logic in_take;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  ucv_decode u_decode (
    .cur_i          (state_q),
    .byte_i         (in_byte_q),
    .last_i         (in_last_q),
    .comment_mode_i (comment_mode),
    .nxt_o          (dec_nxt),
    .res_o          (dec_res)
  );

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);
  assign state_d     = advance ? dec_nxt : state_q;

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload registers, loaded only on a move
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_value_i;
      in_last_q <= last_byte_i;
    end
    if (advance) begin
      out_res_q  <= dec_res;
      out_last_q <= in_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_so_far_o     = out_res_q.ok_so_far;
  assign char_done_o     = out_res_q.char_done;
  assign code_point_o    = out_res_q.code_point;
  assign open_sequence_o = out_res_q.open_sequence;
  assign string_end_o    = out_last_q;

`ifndef SYNTHESIS
  // a code point is only reported when a character completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_done_o |-> code_point_o == '0)
    else $error("code point nonzero without a completed character");

  // an open sequence can only be reported while the string is still clean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_sequence_o |-> ok_so_far_o)
    else $error("open sequence reported after an error");

  // a failing completed character can only come from the comment rule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_done_o && !ok_so_far_o |-> comment_mode)
    else $error("completed character failed outside comment mode");

  // decoding the last byte of a string leaves the decoder clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> state_q == '0)
    else $error("decoder state not cleared at string end");
`endif

endmodule
